// ----- sv/xenc_pkg.sv -----
// Package for the reg/mem operand encoder: command codes, status codes,
// the queued instruction descriptor type and opcode tables. No dependencies.
package xenc_pkg;

  localparam int unsigned MaxBytes = 9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SIZE     = 2'd1,
    ST_MEM_BASE = 2'd2
  } status_t;

  localparam logic [4:0] CMD_NEG    = 5'd0;
  localparam logic [4:0] CMD_SETE   = 5'd4;
  localparam logic [4:0] CMD_SETBE  = 5'd13;
  localparam logic [4:0] CMD_MOV    = 5'd14;
  localparam logic [4:0] CMD_MOVZX  = 5'd15;
  localparam logic [4:0] CMD_MOVSX  = 5'd16;
  localparam logic [4:0] CMD_IMUL   = 5'd22;
  localparam logic [4:0] CMD_TEST   = 5'd23;
  localparam logic [4:0] CMD_CMP    = 5'd24;
  localparam logic [4:0] CMD_LD     = 5'd25;
  localparam logic [4:0] CMD_ST     = 5'd26;
  localparam logic [4:0] CMD_LDX    = 5'd27;
  localparam logic [4:0] CMD_STX    = 5'd28;

  localparam logic [7:0] OP_REX    = 8'h40;
  localparam logic [7:0] OP_OSIZE  = 8'h66;
  localparam logic [7:0] OP_ESC    = 8'h0F;

  // Encoded instruction: up to nine bytes, a byte count and a status.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
    status_t                  status;
  } enc_t;

  function automatic logic [7:0] setcc_op(input logic [3:0] i);
    case (i)
      4'd0: setcc_op = 8'h94;
      4'd1: setcc_op = 8'h95;
      4'd2: setcc_op = 8'h9C;
      4'd3: setcc_op = 8'h9E;
      4'd4: setcc_op = 8'h9F;
      4'd5: setcc_op = 8'h9D;
      4'd6: setcc_op = 8'h97;
      4'd7: setcc_op = 8'h93;
      4'd8: setcc_op = 8'h92;
      default: setcc_op = 8'h96;
    endcase
  endfunction

  function automatic logic [7:0] rr_op(input logic [3:0] i);
    case (i)
      4'd0:  rr_op = 8'h88;
      4'd3:  rr_op = 8'h30;
      4'd4:  rr_op = 8'h20;
      4'd5:  rr_op = 8'h08;
      4'd7:  rr_op = 8'h28;
      4'd9:  rr_op = 8'h84;
      4'd10: rr_op = 8'h38;
      default: rr_op = 8'h00;
    endcase
  endfunction

endpackage

// ----- sv/xenc_front.sv -----
// Front end: accepts one instruction a cycle while its output register is free
// or being taken, and builds its full byte image. Depends on xenc_pkg.
module xenc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        command,
  input  logic [3:0]        first_reg,
  input  logic [1:0]        first_size,
  input  logic [3:0]        second_reg,
  input  logic [1:0]        second_size,
  input  logic [3:0]        third_reg,
  input  logic [1:0]        third_size,
  input  logic [1:0]        scale_log,
  input  logic signed [31:0] displacement,
  output logic              enc_valid,
  input  logic              enc_ready,
  output xenc_pkg::enc_t    enc
);

  xenc_pkg::enc_t enc_r, enc_nxt;
  logic           vld_r;
  logic           keep; // item produces at least one beat

  assign in_ready  = !vld_r || enc_ready;
  assign enc_valid = vld_r;
  assign enc       = enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid && keep;
    end
    if (in_ready) enc_r <= enc_nxt;
  end

  always_comb begin
    logic [7:0] rex, op, modrm;
    logic       need;
    logic [3:0] r1, r2;
    logic [1:0] s1, s2, md;
    logic [2:0] b7;
    logic [3:0] n;
    logic [7:0] e3;
    logic       sml;
    rex = xenc_pkg::OP_REX; need = 1'b0; op = '0; modrm = '0;
    r1 = '0; r2 = '0; s1 = '0; s2 = '0; md = '0; b7 = '0; e3 = '0; sml = 1'b0;
    n = '0;
    enc_nxt = '0;
    enc_nxt.status = xenc_pkg::ST_OK;
    keep = 1'b1;
    if (command <= xenc_pkg::CMD_SETBE) begin
      if (first_reg[3]) begin need = 1'b1; rex[0] = 1'b1; end
      if (first_size == 2'd0 && first_reg[2]) need = 1'b1;
      if (first_size == 2'd3) begin need = 1'b1; rex[3] = 1'b1; end
      if (command < xenc_pkg::CMD_SETE) begin
        case (command[1:0])
          2'd0: e3 = 8'd3;
          2'd1: e3 = 8'd2;
          2'd2: e3 = 8'd6;
          default: e3 = 8'd7;
        endcase
        if (first_size == 2'd1) begin enc_nxt.bytes[n] = xenc_pkg::OP_OSIZE; n = n + 4'd1; end
        if (need) begin enc_nxt.bytes[n] = rex; n = n + 4'd1; end
        enc_nxt.bytes[n] = (first_size == 2'd0) ? 8'hF6 : 8'hF7; n = n + 4'd1;
        enc_nxt.bytes[n] = 8'hC0 | (e3 << 3) | {5'd0, first_reg[2:0]}; n = n + 4'd1;
      end else if (first_size != 2'd0) begin
        enc_nxt.status = xenc_pkg::ST_SIZE;
      end else begin
        if (need) begin enc_nxt.bytes[n] = rex; n = n + 4'd1; end
        enc_nxt.bytes[n] = xenc_pkg::OP_ESC; n = n + 4'd1;
        enc_nxt.bytes[n] = xenc_pkg::setcc_op(4'(command - xenc_pkg::CMD_SETE));
        n = n + 4'd1;
        enc_nxt.bytes[n] = {5'b11000, first_reg[2:0]}; n = n + 4'd1;
      end
    end else if (command == xenc_pkg::CMD_MOVZX || command == xenc_pkg::CMD_MOVSX) begin
      if (first_size <= second_size) begin
        enc_nxt.status = xenc_pkg::ST_SIZE;
      end else begin
        if (first_reg[3]) begin need = 1'b1; rex[2] = 1'b1; end
        if (second_reg[3]) begin need = 1'b1; rex[0] = 1'b1; end
        if (first_size == 2'd0 && first_reg[2]) need = 1'b1;
        if (second_size == 2'd0 && second_reg[2]) need = 1'b1;
        if (first_size == 2'd3) begin need = 1'b1; rex[3] = 1'b1; end
        if (second_size <= 2'd1) begin
          if (second_size == 2'd0 && first_size == 2'd1) begin
            enc_nxt.bytes[n] = xenc_pkg::OP_OSIZE; n = n + 4'd1;
          end
          if (need) begin enc_nxt.bytes[n] = rex; n = n + 4'd1; end
          enc_nxt.bytes[n] = xenc_pkg::OP_ESC; n = n + 4'd1;
          if (second_size == 2'd0)
            enc_nxt.bytes[n] = (command == xenc_pkg::CMD_MOVZX) ? 8'hB6 : 8'hBE;
          else
            enc_nxt.bytes[n] = (command == xenc_pkg::CMD_MOVZX) ? 8'hB7 : 8'hBF;
          n = n + 4'd1;
          enc_nxt.bytes[n] = {2'b11, first_reg[2:0], second_reg[2:0]}; n = n + 4'd1;
        end else if (command == xenc_pkg::CMD_MOVZX) begin
          if (first_reg[3] || second_reg[3]) begin
            enc_nxt.bytes[n] = {5'b01000, second_reg[3], 1'b0, first_reg[3]};
            n = n + 4'd1;
          end
          enc_nxt.bytes[n] = 8'h89; n = n + 4'd1;
          enc_nxt.bytes[n] = {2'b11, second_reg[2:0], first_reg[2:0]}; n = n + 4'd1;
        end else begin
          enc_nxt.bytes[n] = rex; n = n + 4'd1;
          enc_nxt.bytes[n] = 8'h63; n = n + 4'd1;
          enc_nxt.bytes[n] = {2'b11, first_reg[2:0], second_reg[2:0]}; n = n + 4'd1;
        end
      end
    end else if (command <= xenc_pkg::CMD_CMP) begin
      if (command == xenc_pkg::CMD_IMUL || command == xenc_pkg::CMD_TEST) begin
        r1 = second_reg; s1 = second_size; r2 = first_reg; s2 = first_size;
      end else begin
        r1 = first_reg; s1 = first_size; r2 = second_reg; s2 = second_size;
      end
      if (s1 != s2) begin
        enc_nxt.status = xenc_pkg::ST_SIZE;
      end else begin
        if (r1[3]) begin need = 1'b1; rex[0] = 1'b1; end
        if (r2[3]) begin need = 1'b1; rex[2] = 1'b1; end
        if (s1 == 2'd0 && (r1[2] || r2[2])) need = 1'b1;
        if (s1 == 2'd3) begin need = 1'b1; rex[3] = 1'b1; end
        if (command == xenc_pkg::CMD_IMUL) begin
          if (s1 <= 2'd1) begin enc_nxt.bytes[n] = xenc_pkg::OP_OSIZE; n = n + 4'd1; end
          if (need) begin enc_nxt.bytes[n] = rex; n = n + 4'd1; end
          enc_nxt.bytes[n] = xenc_pkg::OP_ESC; n = n + 4'd1;
          enc_nxt.bytes[n] = 8'hAF; n = n + 4'd1;
        end else begin
          op = xenc_pkg::rr_op(4'(command - xenc_pkg::CMD_MOV));
          if (s1 == 2'd1) begin enc_nxt.bytes[n] = xenc_pkg::OP_OSIZE; n = n + 4'd1; end
          if (need) begin enc_nxt.bytes[n] = rex; n = n + 4'd1; end
          enc_nxt.bytes[n] = (s1 == 2'd0) ? op : op + 8'd1; n = n + 4'd1;
        end
        enc_nxt.bytes[n] = {2'b11, r2[2:0], r1[2:0]}; n = n + 4'd1;
      end
    end else if (command <= xenc_pkg::CMD_STX) begin
      sml = (command == xenc_pkg::CMD_LD || command == xenc_pkg::CMD_ST);
      if (second_size != 2'd3 || (!sml && third_size != 2'd3)) begin
        enc_nxt.status = xenc_pkg::ST_MEM_BASE;
      end else begin
        op = (command == xenc_pkg::CMD_LD || command == xenc_pkg::CMD_LDX) ? 8'h8A : 8'h88;
        b7 = second_reg[2:0];
        if (first_size == 2'd3) begin need = 1'b1; rex[3] = 1'b1; end
        if (first_reg[3]) begin need = 1'b1; rex[2] = 1'b1; end
        if (!sml && third_reg[3]) begin need = 1'b1; rex[1] = 1'b1; end
        if (second_reg[3]) begin need = 1'b1; rex[0] = 1'b1; end
        // simple form tests low bits only; indexed form tests the full number
        if (first_size == 2'd0 && (sml ? first_reg[2] : (first_reg >= 4'd4))) need = 1'b1;
        if (displacement == 32'sd0 && b7 != 3'd5) md = 2'd0;
        else if (displacement >= -32'sd128 && displacement <= 32'sd127) md = 2'd1;
        else md = 2'd2;
        if (first_size == 2'd1) begin enc_nxt.bytes[n] = xenc_pkg::OP_OSIZE; n = n + 4'd1; end
        if (need) begin enc_nxt.bytes[n] = rex; n = n + 4'd1; end
        enc_nxt.bytes[n] = (first_size == 2'd0) ? op : op + 8'd1; n = n + 4'd1;
        modrm = {md, first_reg[2:0], sml ? b7 : 3'd4};
        enc_nxt.bytes[n] = modrm; n = n + 4'd1;
        if (!sml) begin
          enc_nxt.bytes[n] = {scale_log, third_reg[2:0], b7}; n = n + 4'd1;
        end else if (b7 == 3'd4) begin
          enc_nxt.bytes[n] = 8'h24; n = n + 4'd1;
        end
        if (md != 2'd0) begin
          enc_nxt.bytes[n] = displacement[7:0]; n = n + 4'd1;
        end
        if (md == 2'd2) begin
          enc_nxt.bytes[n] = displacement[15:8];  n = n + 4'd1;
          enc_nxt.bytes[n] = displacement[23:16]; n = n + 4'd1;
          enc_nxt.bytes[n] = displacement[31:24]; n = n + 4'd1;
        end
      end
    end else begin
      keep = 1'b0;
    end
    enc_nxt.len = (enc_nxt.status == xenc_pkg::ST_OK) ? n : 4'd1;
  end

endmodule

// ----- sv/xenc_queue.sv -----
// Two-entry queue between encoder front end and byte emitter.
// Depends on xenc_pkg.
module xenc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  xenc_pkg::enc_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output xenc_pkg::enc_t rd_data
);

  xenc_pkg::enc_t mem [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'((wr_valid && wr_ready) ? 1 : 0) - 2'((rd_valid && rd_ready) ? 1 : 0);
    end
    if (wr_valid && wr_ready) mem[wp_r] <= wr_data;
  end

endmodule

// ----- sv/xenc_back.sv -----
// Back end: walks one queued encoding out a byte per beat, last on the final.
// Depends on xenc_pkg.
module xenc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  xenc_pkg::enc_t q_data,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_code_byte,
  output logic           out_last,
  output logic [1:0]     out_status
);

  logic [3:0] idx_r;
  logic       fin;

  assign out_empty     = !q_valid;
  assign fin           = (idx_r + 4'd1) >= q_data.len;
  assign out_last      = fin;
  assign out_status    = q_data.status;
  assign out_code_byte = (q_data.status == xenc_pkg::ST_OK) ? q_data.bytes[idx_r] : 8'h00;
  assign q_ready       = out_pop && q_valid && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_pop && q_valid) begin
      idx_r <= fin ? 4'd0 : idx_r + 4'd1;
    end
  end

endmodule

// ----- sv/x86_reg_mem_operand_encoder.sv -----
// x86-64 register/memory operand encoder, top level.
// Depends on xenc_pkg, xenc_front, xenc_queue, xenc_back.
//
// Usage:
//  - Input channel: push/full. One instruction beat is taken on each edge
//    with push high and full low; the front end takes a new instruction
//    every cycle while the queue has room.
//  - Result channel: empty/pop. Each result beat is one code byte plus
//    last and status; the byte on the ports is the oldest not yet popped.
//  - A good encoding yields 2 to 9 beats, last high on the final one.
//    A size, base-width or index-width violation yields one beat, byte 0, status set.
//    Command codes 29..31 yield nothing.
//  - Path: the first byte reaches the ports through the front register, then
//    a queue entry, and is poppable once it is there.
//  - Throughput: the emitter sends one byte per cycle while the receiver
//    pops; the front end and a two-entry queue keep the next instructions
//    ready so there is no bubble between instructions.
//  - Receiver stall: bytes hold on the ports; the queue fills, then the
//    front register, then full rises.
//  - Reset (rst_n low, synchronous) empties every stage.
module x86_reg_mem_operand_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [4:0]        in_command,
  input  logic [3:0]        in_first_reg,
  input  logic [1:0]        in_first_size,
  input  logic [3:0]        in_second_reg,
  input  logic [1:0]        in_second_size,
  input  logic [3:0]        in_third_reg,
  input  logic [1:0]        in_third_size,
  input  logic [1:0]        in_scale_log,
  input  logic signed [31:0] in_displacement,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_code_byte,
  output logic              out_last,
  output logic [1:0]        out_status
);

  logic           in_ready;
  logic           f_valid, f_ready;
  xenc_pkg::enc_t f_data;
  logic           q_valid, q_ready;
  xenc_pkg::enc_t q_data;

  assign in_full = !in_ready;

  xenc_front u_front (
    .clk, .rst_n,
    .in_valid(in_push), .in_ready,
    .command(in_command), .first_reg(in_first_reg), .first_size(in_first_size),
    .second_reg(in_second_reg), .second_size(in_second_size),
    .third_reg(in_third_reg), .third_size(in_third_size),
    .scale_log(in_scale_log), .displacement(in_displacement),
    .enc_valid(f_valid), .enc_ready(f_ready), .enc(f_data)
  );

  xenc_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  xenc_back u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_empty, .out_pop, .out_code_byte, .out_last, .out_status
  );

endmodule

// ----- sv/xenc_checker.sv -----
// Port-level checker for the encoder, bound to the top level.
// Depends on xenc_pkg and the x86_reg_mem_operand_encoder ports.
module xenc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_code_byte,
  input logic       out_last,
  input logic [1:0] out_status
);

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != xenc_pkg::ST_OK) |-> (out_last && out_code_byte == 8'h00))
    else $error("error beat not single");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status != 2'd3)) else $error("bad status");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_code_byte) && $stable(out_last)))
    else $error("stalled beat changed");

  a_ok_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=> (!out_empty && out_status == xenc_pkg::ST_OK))
    else $error("instruction broken");

endmodule

bind x86_reg_mem_operand_encoder xenc_checker u_xenc_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_code_byte, .out_last, .out_status
);

// ----- tb/sv/tb_x86_reg_mem_operand_encoder.sv -----
`timescale 1ns / 100ps
// Testbench for the x86 reg/mem operand encoder: directed and random
// instructions, byte-stream prediction and per-byte checking.
// Depends on xenc_pkg and x86_reg_mem_operand_encoder.
module tb_x86_reg_mem_operand_encoder;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [4:0] in_command = '0;
  logic [3:0] in_first_reg = '0;
  logic [1:0] in_first_size = '0;
  logic [3:0] in_second_reg = '0;
  logic [1:0] in_second_size = '0;
  logic [3:0] in_third_reg = '0;
  logic [1:0] in_third_size = '0;
  logic [1:0] in_scale_log = '0;
  logic signed [31:0] in_displacement = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_code_byte;
  logic out_last;
  logic [1:0] out_status;

  // One instruction as offered on the input ports.
  typedef struct packed {
    logic [4:0]  cmd;
    logic [3:0]  r1;
    logic [1:0]  s1;
    logic [3:0]  r2;
    logic [1:0]  s2;
    logic [3:0]  r3;
    logic [1:0]  s3;
    logic [1:0]  scale;
    logic [31:0] disp;
  } insn_t;

  // One expected output beat.
  typedef struct packed {
    logic [7:0]        code;
    logic              last;
    xenc_pkg::status_t status;
  } code_beat_t;

  code_beat_t pending_bytes[$];
  code_beat_t enc_buf[$];
  int errors = 0;
  int n_insn = 0;
  int n_bytes = 0;
  int n_err_beats = 0;
  int hold_cycles = 0;   // receiver hold-off, counted down by the pop process
  int long_gaps = 1;     // 0 turns off idling on both sides

  x86_reg_mem_operand_encoder u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0h want %0h (beat %0d)", what, got, want, n_bytes);
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] setcc_code(input int i);
    logic [7:0] t[10] = '{8'h94, 8'h95, 8'h9C, 8'h9E, 8'h9F, 8'h9D, 8'h97, 8'h93, 8'h92, 8'h96};
    return t[i];
  endfunction

  function automatic logic [7:0] alu_code(input int i);
    logic [7:0] t[11] = '{8'h88, 0, 0, 8'h30, 8'h20, 8'h08, 0, 8'h28, 0, 8'h84, 8'h38};
    return t[i];
  endfunction

  function automatic logic [1:0] disp_mode(input logic [31:0] dv, input logic [2:0] b7);
    logic signed [31:0] s;
    s = dv;
    if (s == 0 && b7 != 3'd5) return 2'd0;
    if (s >= -128 && s <= 127) return 2'd1;
    return 2'd2;
  endfunction

  task automatic emit(input logic [7:0] b);
    enc_buf.push_back('{b, 1'b0, xenc_pkg::ST_OK});
  endtask

  task automatic emit_disp(input logic [1:0] mode, input logic [31:0] dv);
    if (mode == 2'd1) emit(dv[7:0]);
    if (mode == 2'd2) begin
      emit(dv[7:0]); emit(dv[15:8]); emit(dv[23:16]); emit(dv[31:24]);
    end
  endtask

  // Builds the code bytes of one instruction into enc_buf; returns an error
  // status, ST_OK when the bytes are good. Unused commands leave it empty.
  task automatic encode_insn(input insn_t t, output xenc_pkg::status_t st);
    logic [7:0] rex, opb, op;
    logic need, zx;
    logic [3:0] a, b, p, q;
    logic [1:0] sa, sb, sp, sq, md;
    logic [2:0] ext[4] = '{3'd3, 3'd2, 3'd6, 3'd7};
    enc_buf.delete();
    st = xenc_pkg::ST_OK;
    a = t.r1; sa = t.s1; b = t.r2; sb = t.s2;
    rex = xenc_pkg::OP_REX; need = 1'b0;
    if (t.cmd <= xenc_pkg::CMD_SETBE) begin
      if (a[3]) begin need = 1; rex[0] = 1; end
      if (sa == 0 && a[2]) need = 1;
      if (sa == 3) begin need = 1; rex[3] = 1; end
      if (t.cmd < xenc_pkg::CMD_SETE) begin
        if (sa == 1) emit(xenc_pkg::OP_OSIZE);
        if (need) emit(rex);
        emit(sa == 0 ? 8'hF6 : 8'hF7);
        emit({2'b11, ext[t.cmd], a[2:0]});
      end else if (sa != 0) st = xenc_pkg::ST_SIZE;
      else begin
        if (need) emit(rex);
        emit(xenc_pkg::OP_ESC);
        emit(setcc_code(t.cmd - xenc_pkg::CMD_SETE));
        emit({5'b11000, a[2:0]});
      end
    end else if (t.cmd == xenc_pkg::CMD_MOVZX || t.cmd == xenc_pkg::CMD_MOVSX) begin
      zx = (t.cmd == xenc_pkg::CMD_MOVZX);
      if (sa <= sb) st = xenc_pkg::ST_SIZE;
      else begin
        if (a[3]) begin need = 1; rex[2] = 1; end
        if (b[3]) begin need = 1; rex[0] = 1; end
        if (sa == 0 && a[2]) need = 1;
        if (sb == 0 && b[2]) need = 1;
        if (sa == 3) begin need = 1; rex[3] = 1; end
        if (sb <= 1) begin
          if (sb == 0 && sa == 1) emit(xenc_pkg::OP_OSIZE);
          if (need) emit(rex);
          emit(xenc_pkg::OP_ESC);
          if (sb == 0) emit(zx ? 8'hB6 : 8'hBE);
          else emit(zx ? 8'hB7 : 8'hBF);
          emit({2'b11, a[2:0], b[2:0]});
        end else if (zx) begin
          // 32-bit source: a plain 32-bit MOV zero-extends
          rex = xenc_pkg::OP_REX; need = 0;
          if (a[3]) begin need = 1; rex[0] = 1; end
          if (b[3]) begin need = 1; rex[2] = 1; end
          if (need) emit(rex);
          emit(8'h89);
          emit({2'b11, b[2:0], a[2:0]});
        end else begin
          emit(rex);
          emit(8'h63);
          emit({2'b11, a[2:0], b[2:0]});
        end
      end
    end else if (t.cmd <= xenc_pkg::CMD_CMP) begin
      p = a; sp = sa; q = b; sq = sb;
      if (t.cmd == xenc_pkg::CMD_IMUL || t.cmd == xenc_pkg::CMD_TEST) begin
        p = b; sp = sb; q = a; sq = sa;
      end
      if (sp != sq) st = xenc_pkg::ST_SIZE;
      else begin
        if (p[3]) begin need = 1; rex[0] = 1; end
        if (q[3]) begin need = 1; rex[2] = 1; end
        if (sp == 0 && p[2]) need = 1;
        if (sq == 0 && q[2]) need = 1;
        if (sp == 3) begin need = 1; rex[3] = 1; end
        if (t.cmd == xenc_pkg::CMD_IMUL) begin
          if (sp <= 1) emit(xenc_pkg::OP_OSIZE);
          if (need) emit(rex);
          emit(xenc_pkg::OP_ESC);
          emit(8'hAF);
        end else begin
          op = alu_code(t.cmd - xenc_pkg::CMD_MOV);
          if (sp == 1) emit(xenc_pkg::OP_OSIZE);
          if (need) emit(rex);
          emit(sp == 0 ? op : op + 8'd1);
        end
        emit({2'b11, q[2:0], p[2:0]});
      end
    end else if (t.cmd <= xenc_pkg::CMD_STX) begin
      opb = (t.cmd == xenc_pkg::CMD_LD || t.cmd == xenc_pkg::CMD_LDX) ? 8'h8A : 8'h88;
      if (sb != 3 || (t.cmd >= xenc_pkg::CMD_LDX && t.s3 != 3)) st = xenc_pkg::ST_MEM_BASE;
      else begin
        if (sa == 3) begin need = 1; rex[3] = 1; end
        if (a[3]) begin need = 1; rex[2] = 1; end
        if (t.cmd >= xenc_pkg::CMD_LDX && t.r3[3]) begin need = 1; rex[1] = 1; end
        if (b[3]) begin need = 1; rex[0] = 1; end
        // byte register rule differs: full number in the indexed form
        if (sa == 0 && (t.cmd >= xenc_pkg::CMD_LDX ? a >= 4 : a[2])) need = 1;
        if (sa == 1) emit(xenc_pkg::OP_OSIZE);
        if (need) emit(rex);
        emit(sa == 0 ? opb : opb + 8'd1);
        md = disp_mode(t.disp, b[2:0]);
        if (t.cmd >= xenc_pkg::CMD_LDX) begin
          emit({md, a[2:0], 3'd4});
          emit({t.scale, t.r3[2:0], b[2:0]});
        end else begin
          emit({md, a[2:0], b[2:0]});
          if (b[2:0] == 3'd4) emit(8'h24);
        end
        emit_disp(md, t.disp);
      end
    end
  endtask

  // ------------------------------------------------------------- drive/check
  // push stays high into the next call when there is no gap
  task automatic send_insn(input insn_t t);
    xenc_pkg::status_t st;
    int gap;
    gap = 0;
    if (long_gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    encode_insn(t, st);
    if (st != xenc_pkg::ST_OK) begin
      pending_bytes.push_back('{8'h00, 1'b1, st});
    end else if (enc_buf.size() > 0) begin
      enc_buf[enc_buf.size() - 1].last = 1'b1;
      foreach (enc_buf[k]) pending_bytes.push_back(enc_buf[k]);
    end
    {in_command, in_first_reg, in_first_size, in_second_reg, in_second_size,
     in_third_reg, in_third_size, in_scale_log, in_displacement} = t;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n_insn++;
    @(negedge clk);
  endtask

  // pop side: random stalls, plus a hold-off when hold_cycles is set
  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_pop <= 1'b0;
    end else if (!long_gaps) out_pop <= 1'b1;
    else out_pop <= ($urandom_range(0, 29) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    code_beat_t w;
    if (rst_n && out_pop && !out_empty) begin
      n_bytes++;
      if (out_status != xenc_pkg::ST_OK) n_err_beats++;
      if (pending_bytes.size() == 0) report("unexpected beat", out_code_byte, 0);
      else begin
        w = pending_bytes.pop_front();
        if (out_code_byte !== w.code) report("code_byte", out_code_byte, w.code);
        if (out_last !== w.last) report("last", out_last, w.last);
        if (out_status !== w.status) report("status", out_status, w.status);
      end
    end
  end

  function automatic logic [31:0] rand_disp();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(0, 255) - 128;
      2: return $urandom_range(0, 1) ? 32'sd128 : -32'sd129;
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic insn_t rand_insn(input bit good);
    insn_t t;
    t = '{$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 3),
          $urandom_range(0, 15), $urandom_range(0, 3), $urandom_range(0, 15),
          $urandom_range(0, 3), $urandom_range(0, 3), rand_disp()};
    if (good) begin
      t.cmd = $urandom_range(0, 28);
      if (t.cmd >= xenc_pkg::CMD_LD) begin t.s2 = 3; t.s3 = 3; end
      else if (t.cmd >= xenc_pkg::CMD_SETE && t.cmd <= xenc_pkg::CMD_SETBE) t.s1 = 0;
      else if (t.cmd == xenc_pkg::CMD_MOVZX || t.cmd == xenc_pkg::CMD_MOVSX) begin
        t.s1 = $urandom_range(1, 3); t.s2 = $urandom_range(0, t.s1 - 1);
      end else if (t.cmd >= xenc_pkg::CMD_MOV) t.s2 = t.s1;
    end
    return t;
  endfunction

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(negedge clk); while (pending_bytes.size() != 0);
  endtask

  // ----------------------------------------------------------------- tests
  task automatic test_directed();
    insn_t t;
    // command codes 0..28 once each, plus unused code 31, with extreme registers and a large displacement
    for (int c = 0; c < 32; c++) begin
      if (c > 28 && c != 31) continue;
      t = '{c[4:0], 4'd15, 2'd3, 4'd15, 2'd3, 4'd15, 2'd3, 2'd3, 32'h8000_0000};
      if (c >= xenc_pkg::CMD_SETE && c <= xenc_pkg::CMD_SETBE) t.s1 = 0;
      if (c == xenc_pkg::CMD_MOVZX || c == xenc_pkg::CMD_MOVSX) t.s2 = 2;
      send_insn(t);
    end
    // SIL needs REX
    send_insn('{xenc_pkg::CMD_SETE, 4'd6, 2'd0, 4'd0, 2'd0, 4'd0, 2'd0, 2'd0, 0});
    // non-byte SETcc
    send_insn('{xenc_pkg::CMD_SETE, 4'd1, 2'd2, 4'd0, 2'd0, 4'd0, 2'd0, 2'd0, 0});
    // size mismatch
    send_insn('{xenc_pkg::CMD_MOV, 4'd1, 2'd2, 4'd2, 2'd3, 4'd0, 2'd0, 2'd0, 0});
    // not widening
    send_insn('{xenc_pkg::CMD_MOVZX, 4'd1, 2'd0, 4'd2, 2'd1, 4'd0, 2'd0, 2'd0, 0});
    // from 32 bits
    send_insn('{xenc_pkg::CMD_MOVZX, 4'd9, 2'd3, 4'd4, 2'd2, 4'd0, 2'd0, 2'd0, 0});
    // 66 prefix
    send_insn('{xenc_pkg::CMD_MOVSX, 4'd1, 2'd1, 4'd5, 2'd0, 4'd0, 2'd0, 2'd0, 0});
    // byte IMUL
    send_insn('{xenc_pkg::CMD_IMUL, 4'd0, 2'd0, 4'd7, 2'd0, 4'd0, 2'd0, 2'd0, 0});
    // rbp, zero disp
    send_insn('{xenc_pkg::CMD_LD, 4'd0, 2'd2, 4'd5, 2'd3, 4'd0, 2'd0, 2'd0, 0});
    // r12 SIB
    send_insn('{xenc_pkg::CMD_ST, 4'd4, 2'd0, 4'd12, 2'd3, 4'd0, 2'd0, 2'd0, 32'd127});
    // base not 64-bit
    send_insn('{xenc_pkg::CMD_LD, 4'd0, 2'd1, 4'd1, 2'd2, 4'd0, 2'd0, 2'd0, 0});
    // index 4, r13
    send_insn('{xenc_pkg::CMD_LDX, 4'd3, 2'd0, 4'd13, 2'd3, 4'd4, 2'd3, 2'd2, 0});
    // index not 64-bit
    send_insn('{xenc_pkg::CMD_STX, 4'd0, 2'd3, 4'd0, 2'd3, 4'd1, 2'd2, 2'd1, 0});
    send_insn('{xenc_pkg::CMD_STX, 4'd7, 2'd1, 4'd0, 2'd3, 4'd1, 2'd3, 2'd0, 32'h7FFF_FFFF});
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 290; i++) begin
      long_gaps = (i % 100) < 80;
      send_insn(rand_insn($urandom_range(0, 4) != 0));
    end
    long_gaps = 1;
    wait_drained();
  endtask

  // receiver stops while the sender keeps offering, so full must rise
  task automatic test_backpressure();
    long_gaps = 0;
    hold_cycles = 60;
    for (int i = 0; i < 20; i++) send_insn(rand_insn(1));
    long_gaps = 1;
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    repeat (20) @(negedge clk);
    $display("covered %0d instructions, %0d code beats (%0d error beats)",
             n_insn, n_bytes, n_err_beats);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/xenc_pkg.sv
sv/xenc_front.sv
sv/xenc_queue.sv
sv/xenc_back.sv
sv/x86_reg_mem_operand_encoder.sv
sv/xenc_checker.sv
tb/sv/tb_x86_reg_mem_operand_encoder.sv
